// ===== hw/rtl/node_pool_list_allocator_macros.svh =====
// Assertion macros for the node pool list allocator.
`ifndef NODE_POOL_LIST_ALLOCATOR_MACROS_SVH
`define NODE_POOL_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NPLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define NPLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/npla_pkg.sv =====
// Package: field widths, codes and controller/datapath handshake types.
package npla_pkg;

  localparam int CMD_W      = 2;
  localparam int REQ_IDX_W  = 5;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_ALLOC_HEAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_TAIL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE       = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 1'd1;

  typedef struct packed {
    logic accept;
    logic unlink;
    logic place;
    logic finish;
    logic init_wr;
  } npla_cmd_t;

  typedef struct packed {
    logic init_last;
    logic out_free;
  } npla_stat_t;

endpackage

// ===== hw/rtl/npla_req_if.sv =====
// Request channel: command and node index.
interface npla_req_if import npla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [REQ_IDX_W-1:0] node_index;

  modport source (output valid, command, node_index, input ready);
  modport sink (input valid, command, node_index, output ready);
endinterface

// ===== hw/rtl/npla_rsp_if.sv =====
// Result channel: status, node index and element address.
interface npla_rsp_if import npla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [REQ_IDX_W-1:0] result_index;
  logic [ADDR_W-1:0]    element_address;

  modport source (output valid, status, result_index, element_address, input ready);
  modport sink (input valid, status, result_index, element_address, output ready);
endinterface

// ===== hw/rtl/npla_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface npla_cfg_if import npla_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/npla_ctrl.sv =====
// Controller: link store clearing pass and per-request step sequencing.
module npla_ctrl import npla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  npla_stat_t stat,
  output npla_cmd_t  cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_UNLINK = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/npla_dp.sv =====
// Datapath: link stores, list pointers, config registers and result register.
module npla_dp import npla_pkg::*; #(
  parameter int POOL_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  npla_cmd_t             cmd,
  output npla_stat_t            stat,
  input  logic [CMD_W-1:0]      command,
  input  logic [REQ_IDX_W-1:0]  node_index,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [REQ_IDX_W-1:0]  result_index,
  output logic [ADDR_W-1:0]     element_address
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int CW = ((IW > REQ_IDX_W) ? IW : REQ_IDX_W) + 1;
  localparam int PW = IW + SIZE_W;
  localparam logic [LW-1:0] NIL  = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(POOL_DEPTH - 1);

  logic [LW-1:0] prev_mem [POOL_DEPTH];
  logic [LW-1:0] next_mem [POOL_DEPTH];
  logic          alloc_mem [POOL_DEPTH];

  logic [ADDR_W-1:0] base;
  logic [SIZE_W-1:0] size;
  logic [IW-1:0]     init_cnt;
  logic [LW-1:0]     fhead, ftail, ahead, atail;
  logic [LW-1:0]     prev_rd, next_rd;
  logic              alloc_rd;
  logic [IW-1:0]     node;
  logic              is_free, at_tail, req_ok, ok;
  logic [PW-1:0]     prod;

  logic              req_in_range;
  logic [IW-1:0]     rd_addr;
  logic              ok_c;

  logic              prev_we, next_we, alloc_we;
  logic [IW-1:0]     prev_wa, next_wa, alloc_wa;
  logic [LW-1:0]     prev_wd, next_wd;
  logic              alloc_wd;

  assign req_in_range = CW'(node_index) < CW'(POOL_DEPTH);

  always_comb begin
    if (command[1]) begin
      rd_addr = req_in_range ? IW'(node_index) : '0;
    end else begin
      rd_addr = (fhead != NIL) ? fhead[IW-1:0] : '0;
    end
  end

  assign ok_c = is_free ? (req_ok && alloc_rd) : (fhead != NIL);

  assign stat.init_last = (init_cnt == LAST);
  assign stat.out_free  = !out_valid || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      size <= SIZE_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DATA_BASE:    base <= cfg_data;
        REG_ELEMENT_SIZE: size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
    end else if (cmd.init_wr) begin
      init_cnt <= init_cnt + IW'(1);
    end
  end

  // link store write selection
  always_comb begin
    prev_we  = 1'b0;
    next_we  = 1'b0;
    alloc_we = 1'b0;
    prev_wa  = node;
    next_wa  = node;
    alloc_wa = node;
    prev_wd  = NIL;
    next_wd  = NIL;
    alloc_wd = 1'b0;
    if (cmd.init_wr) begin
      prev_we  = 1'b1;
      next_we  = 1'b1;
      alloc_we = 1'b1;
      prev_wa  = init_cnt;
      next_wa  = init_cnt;
      alloc_wa = init_cnt;
      prev_wd  = (init_cnt == '0) ? NIL : LW'(init_cnt - IW'(1));
      next_wd  = (init_cnt == LAST) ? NIL : LW'(init_cnt) + LW'(1);
    end else if (cmd.unlink && ok_c) begin
      if (prev_rd != NIL) begin
        next_we = 1'b1;
        next_wa = prev_rd[IW-1:0];
        next_wd = next_rd;
      end
      if (next_rd != NIL) begin
        prev_we = 1'b1;
        prev_wa = next_rd[IW-1:0];
        prev_wd = prev_rd;
      end
      alloc_we = 1'b1;
      alloc_wd = !is_free;
    end else if (cmd.place && ok) begin
      prev_we = 1'b1;
      next_we = 1'b1;
      if (is_free) begin
        next_wd = fhead;
      end else if (at_tail) begin
        prev_wd = atail;
      end else begin
        next_wd = ahead;
      end
    end else if (cmd.finish && ok) begin
      if (is_free) begin
        prev_we = (fhead != NIL);
        prev_wa = fhead[IW-1:0];
        prev_wd = LW'(node);
      end else if (at_tail) begin
        next_we = (atail != NIL);
        next_wa = atail[IW-1:0];
        next_wd = LW'(node);
      end else begin
        prev_we = (ahead != NIL);
        prev_wa = ahead[IW-1:0];
        prev_wd = LW'(node);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (alloc_we) begin
      alloc_mem[alloc_wa] <= alloc_wd;
    end
  end

  // request capture and registered link read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_rd  <= prev_mem[rd_addr];
      next_rd  <= next_mem[rd_addr];
      alloc_rd <= alloc_mem[rd_addr];
      node     <= rd_addr;
      is_free  <= command[1];
      at_tail  <= command[0];
      req_ok   <= req_in_range;
    end
    if (cmd.unlink) begin
      ok   <= ok_c;
      prod <= PW'(node) * PW'(size);
    end
  end

  // list head and tail pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fhead <= '0;
      ftail <= LW'(LAST);
      ahead <= NIL;
      atail <= NIL;
    end else if (cmd.unlink && ok_c) begin
      if (is_free) begin
        if (prev_rd == NIL) ahead <= next_rd;
        if (next_rd == NIL) atail <= prev_rd;
      end else begin
        if (prev_rd == NIL) fhead <= next_rd;
        if (next_rd == NIL) ftail <= prev_rd;
      end
    end else if (cmd.finish && ok) begin
      if (is_free) begin
        fhead <= LW'(node);
        if (fhead == NIL) ftail <= LW'(node);
      end else if (at_tail) begin
        atail <= LW'(node);
        if (atail == NIL) ahead <= LW'(node);
      end else begin
        ahead <= LW'(node);
        if (ahead == NIL) atail <= LW'(node);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (ok) begin
        status          <= ST_OK;
        result_index    <= REQ_IDX_W'(node);
        element_address <= base + ADDR_W'(prod);
      end else begin
        status          <= is_free ? ST_NOT_ALLOC : ST_EMPTY;
        result_index    <= '0;
        element_address <= base;
      end
    end
  end

endmodule

// ===== hw/rtl/node_pool_list_allocator.sv =====
// Top level: node pool allocator keeping free and active doubly linked lists.
//
// Channels: req takes a command (allocate at active head, allocate at active
// tail, free node) with a node index; rsp returns status, node index and the
// element address data_base + index * element_size; cfg writes data_base
// (index 0) and element_size (index 1) and is always ready.
// The link stores are read when a request is accepted, then three link
// update steps follow (unlink, place, finish), each at most one write per
// link store, and the result is loaded in the finish step. The next request
// is accepted in the cycle after the result is loaded.
// After reset the block runs a clearing pass over all POOL_DEPTH entries that
// rebuilds the free list in index order; req.ready stays low meanwhile.
// A stalled result sits in the output register; a following request is still
// accepted and worked, and waits in its last step until the register frees.
`include "node_pool_list_allocator_macros.svh"

module node_pool_list_allocator import npla_pkg::*; #(
  parameter int POOL_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  npla_req_if.sink   req,
  npla_rsp_if.source rsp,
  npla_cfg_if.sink   cfg
);

  npla_cmd_t  cmd;
  npla_stat_t stat;

  assign cfg.ready = 1'b1;

  npla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npla_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (req.command),
    .node_index      (req.node_index),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .result_index    (rsp.result_index),
    .element_address (rsp.element_address)
  );

  `NPLA_ASSERT_NXT(a_one_request, req.valid && req.ready, !req.ready, "request overlap")
  `NPLA_ASSERT_IMP(a_status_code, rsp.valid, rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_NOT_ALLOC, "bad status code")
  `NPLA_ASSERT_IMP(a_err_index, rsp.valid && rsp.status != ST_OK, rsp.result_index == '0, "nonzero index on error")
  `NPLA_ASSERT_IMP(a_finish_free, cmd.finish, !rsp.valid || rsp.ready, "result overwritten")

endmodule

// ===== dv/node_pool_list_allocator_tb.sv =====
// Testbench for node_pool_list_allocator: results checked against a shadow list model.
module node_pool_list_allocator_tb;
  import npla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam logic [5:0] NO_NODE = 6'(DEPTH);
  localparam logic [CMD_W-1:0] CMD_FREE_ALIAS = CMD_FREE | CMD_ALLOC_TAIL;
  localparam int PHASE_ITEMS = 320;
  localparam int SETTLE = 4;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [REQ_IDX_W-1:0] node;
  } pool_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [REQ_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    addr;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst;

  npla_req_if req_ch();
  npla_rsp_if rsp_ch();
  npla_cfg_if cfg_ch();

  node_pool_list_allocator #(.POOL_DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #6 clk = ~clk;

  // shadow of the link stores, list ends and layout registers
  logic [5:0]        link_prev [DEPTH];
  logic [5:0]        link_next [DEPTH];
  logic [5:0]        spare_head, spare_tail, act_head, act_tail;
  bit                node_busy [DEPTH];
  logic [ADDR_W-1:0] base_m;
  logic [SIZE_W-1:0] size_m;

  pool_req_t    pending[$];
  pool_result_t expected[$];
  bit           gaps_on;
  int           gap_left, stall_left;
  int           errors, requests_taken, results_seen, layouts;
  int           status_seen [4];

  function automatic void model_reset();
    for (int i = 0; i < DEPTH; i++) begin
      link_prev[i] = (i == 0) ? NO_NODE : 6'(i - 1);
      link_next[i] = (i == DEPTH - 1) ? NO_NODE : 6'(i + 1);
      node_busy[i] = 1'b0;
    end
    spare_head = '0;
    spare_tail = 6'(DEPTH - 1);
    act_head   = NO_NODE;
    act_tail   = NO_NODE;
    base_m     = '0;
    size_m     = 16'd1;
  endfunction

  function automatic void chain_unlink(inout logic [5:0] hd, inout logic [5:0] tl,
                                       input logic [5:0] n);
    logic [5:0] p, q;
    p = link_prev[n];
    q = link_next[n];
    if (p < DEPTH) link_next[p] = q; else hd = q;
    if (q < DEPTH) link_prev[q] = p; else tl = p;
    link_prev[n] = NO_NODE;
    link_next[n] = NO_NODE;
  endfunction

  function automatic void chain_push_head(inout logic [5:0] hd, inout logic [5:0] tl,
                                          input logic [5:0] n);
    link_prev[n] = NO_NODE;
    link_next[n] = hd;
    if (hd < DEPTH) link_prev[hd] = n; else tl = n;
    hd = n;
  endfunction

  function automatic void chain_push_tail(inout logic [5:0] hd, inout logic [5:0] tl,
                                          input logic [5:0] n);
    link_next[n] = NO_NODE;
    link_prev[n] = tl;
    if (tl < DEPTH) link_next[tl] = n; else hd = n;
    tl = n;
  endfunction

  // only the high command bit selects free
  function automatic pool_result_t serve_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [REQ_IDX_W-1:0] ni);
    pool_result_t r;
    logic [5:0]   n;
    r.status = ST_OK;
    r.index  = '0;
    if (cmd[1]) begin
      if (node_busy[ni]) begin
        chain_unlink(act_head, act_tail, {1'b0, ni});
        chain_push_head(spare_head, spare_tail, {1'b0, ni});
        node_busy[ni] = 1'b0;
        r.index = ni;
      end else begin
        r.status = ST_NOT_ALLOC;
      end
    end else begin
      n = spare_head;
      if (n < DEPTH) begin
        chain_unlink(spare_head, spare_tail, n);
        if (cmd == CMD_ALLOC_HEAD) chain_push_head(act_head, act_tail, n);
        else chain_push_tail(act_head, act_tail, n);
        node_busy[n[4:0]] = 1'b1;
        r.index = n[4:0];
      end else begin
        r.status = ST_EMPTY;
      end
    end
    r.addr = base_m + 32'(r.index) * 32'(size_m);
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [REQ_IDX_W-1:0] pick_free_target();
    logic [REQ_IDX_W-1:0] held[$];
    for (int i = 0; i < DEPTH; i++)
      if (node_busy[i]) held.push_back(5'(i));
    if (held.size() != 0 && $urandom_range(0, 99) < 80)
      return held[$urandom_range(0, held.size() - 1)];
    return 5'($urandom);
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [REQ_IDX_W-1:0] node);
    pool_req_t it;
    while (pending.size() >= 2) @(negedge clk);
    it.cmd  = cmd;
    it.node = node;
    pending.push_back(it);
  endtask

  task automatic queue_random(input int alloc_pct);
    logic [CMD_W-1:0]     cmd;
    logic [REQ_IDX_W-1:0] node;
    while (pending.size() >= 2) @(negedge clk);
    if ($urandom_range(0, 99) < alloc_pct) begin
      cmd  = $urandom_range(0, 1) ? CMD_ALLOC_TAIL : CMD_ALLOC_HEAD;
      node = 5'($urandom);
    end else begin
      cmd  = ($urandom_range(0, 19) == 0) ? CMD_FREE_ALIAS : CMD_FREE;
      node = pick_free_target();
    end
    queue_item(cmd, node);
  endtask

  task automatic drain(input int extra);
    while (pending.size() != 0 || req_ch.valid || expected.size() != 0) @(negedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DATA_BASE) base_m = val;
    else size_m = val[SIZE_W-1:0];
  endtask

  task automatic set_layout(input logic [ADDR_W-1:0] b, input logic [SIZE_W-1:0] s);
    @(posedge clk);
    write_reg(REG_DATA_BASE, b);
    write_reg(REG_ELEMENT_SIZE, {16'($urandom), s});
    cfg_ch.valid <= 1'b0;
    layouts++;
  endtask

  task automatic note_mismatch(input string what, input pool_result_t want,
                               input pool_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected status %0d index %0d addr %h, got status %0d index %0d addr %h",
               $realtime, what, want.status, want.index, want.addr,
               got.status, got.index, got.addr);
  endtask

  // request driver
  always @(posedge clk) begin : drv
    pool_req_t nxt;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        expected.push_back(serve_request(req_ch.command, req_ch.node_index));
        requests_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.command    <= nxt.cmd;
          req_ch.node_index <= nxt.node;
          gap_left = pick_idle();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    pool_result_t want, got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.index  = rsp_ch.result_index;
        got.addr   = rsp_ch.element_address;
        results_seen++;
        status_seen[got.status]++;
        if (expected.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected.pop_front();
          if (got.status !== want.status) note_mismatch("status", want, got);
          else if (got.index !== want.index) note_mismatch("result_index", want, got);
          else if (got.addr !== want.addr) note_mismatch("element_address", want, got);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] b;
    logic [SIZE_W-1:0] s;
    int                sent, len, pct;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_ALLOC_HEAD;
    req_ch.node_index = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DATA_BASE;
    cfg_ch.data = '0;
    model_reset();
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset layout, frees of idle nodes, both alloc ends, unlink at
    // head, middle and tail, double free, and the aliased free command
    queue_item(CMD_FREE, 5'd0);
    queue_item(CMD_FREE_ALIAS, 5'd31);
    queue_item(CMD_ALLOC_HEAD, 5'd31);
    queue_item(CMD_ALLOC_TAIL, 5'd0);
    queue_item(CMD_ALLOC_HEAD, 5'd17);
    queue_item(CMD_FREE, 5'd0);
    queue_item(CMD_FREE, 5'd2);
    queue_item(CMD_FREE, 5'd1);
    queue_item(CMD_FREE, 5'd1);
    queue_item(CMD_ALLOC_TAIL, 5'd0);
    queue_item(CMD_ALLOC_TAIL, 5'd0);
    queue_item(CMD_ALLOC_HEAD, 5'd0);
    queue_item(CMD_FREE_ALIAS, 5'd1);
    queue_item(CMD_FREE, 5'd31);
    drain(SETTLE);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin b = 32'h8000_0000; s = 16'd4;         gaps_on = 1'b1; end
        1: begin b = 32'hFFFF_FFFF; s = 16'hFFFF;      gaps_on = 1'b0; end
        2: begin b = 32'h0;         s = 16'd0;         gaps_on = 1'b1; end
        3: begin b = $urandom;      s = 16'($urandom); gaps_on = 1'b1; end
        default: begin b = 32'hFFFF_F000; s = 16'd1;   gaps_on = 1'b1; end
      endcase
      set_layout(b, s);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // each phase opens by running the pool dry, then churns at mixed rates
        if (sent == 0) begin
          pct = 100;
          len = 36;
        end else begin
          case ($urandom_range(0, 3))
            0: pct = 100;
            1: pct = 80;
            2: pct = 50;
            default: pct = 15;
          endcase
          len = $urandom_range(10, 60);
        end
        repeat (len) begin
          queue_random(pct);
          sent++;
        end
      end
      drain(SETTLE);
    end

    drain(8);
    $display("Covered %0d requests under %0d address layouts, %0d results checked.",
             requests_taken, layouts + 1, results_seen);
    $display("Status mix: %0d ok, %0d pool empty, %0d not allocated; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_ALLOC], errors);
    if (errors == 0 && expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
